// ===== rtl/inikv_pkg.sv =====
`timescale 1ns / 1ps
package inikv_pkg;

   localparam int LINE_CHARS = 80;
   localparam int NUM_KEYS   = 6;

   localparam int COL_W = $clog2(LINE_CHARS);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_CHARS - 1);

   localparam int MASK_W      = 6;
   localparam int KEY_W       = 64;
   localparam int KEY_BYTES   = 8;
   localparam int KBYTE_IDX_W = 3;
   localparam int VALUE_W     = 16;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KIND_MASK = 3'd6;

   localparam logic [7:0] BYTE_EOL     = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_EOF     = 8'h00;
   localparam logic [7:0] BYTE_SEMI    = 8'h3B;
   localparam logic [7:0] BYTE_EQ      = 8'h3D;
   localparam logic [7:0] BYTE_SP      = 8'h20;
   localparam logic [7:0] BYTE_DIGIT_0 = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9 = 8'h39;

   localparam int KLEN_W = 4;
   localparam logic [KLEN_W-1:0] KLEN_MAX  = 4'd8;
   localparam logic [KLEN_W-1:0] KLEN_OVER = 4'd9;

   localparam int VLEN_W = 3;
   localparam logic [VLEN_W-1:0] VLEN_MAX = 3'd5;
   localparam logic [VLEN_W-1:0] VLEN_SAT = 3'd6;

   localparam logic [VALUE_W-1:0] VALUE_CAP_TENTH = 16'd6553;
   localparam logic [3:0]         VALUE_CAP_DIGIT = 4'd6;
   localparam logic [VALUE_W-1:0] VALUE_KEY_ONLY  = 16'd1;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_COMMENT = 3'b010,
      MODE_KV      = 3'b100
   } mode_type;

   typedef enum logic [2:0] {
      K_LEAD = 3'b001,
      K_RUN  = 3'b010,
      K_DONE = 3'b100
   } kphase_type;

   typedef enum logic [3:0] {
      V_PRE  = 4'b0001,
      V_LEAD = 4'b0010,
      V_RUN  = 4'b0100,
      V_DONE = 4'b1000
   } vphase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_FINISH = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic need_finish;
      logic emit;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== rtl/ini_key_value_line_parser_top.sv =====
// Content bytes, and bytes inside a comment other than 0x00, are accepted without a stall.
// A ';' or 0x0A outside a comment, and 0x00 anywhere, are transferred, then evaluated into
// the output register during a stall; the result is visible the cycle after evaluation.
// An evaluation that produces a result waits while a stalled result still holds the output.
// Reset is synchronous, active high: clears keys, kind mask, mode, column, overflow and valids.
`timescale 1ns / 1ps
module ini_key_value_line_parser_top import inikv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [MASK_W-1:0]    rsp_match_mask,
   output logic [VALUE_W-1:0]   rsp_setting_value,
   output logic                 rsp_key_only_line,
   output logic                 rsp_line_too_long,
   output logic                 rsp_end_of_file,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   inikv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   inikv_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_data_byte     (req_data_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_match_mask    (rsp_match_mask),
      .rsp_setting_value (rsp_setting_value),
      .rsp_key_only_line (rsp_key_only_line),
      .rsp_line_too_long (rsp_line_too_long),
      .rsp_end_of_file   (rsp_end_of_file)
   );

   a_term_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && dp_status.need_finish) |=> req_stall)
      else $error("terminator transfer did not enter evaluation");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.finish))
      else $error("result appeared without line evaluation");

   a_too_long_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_too_long) |->
         (rsp_match_mask == '0 && rsp_setting_value == '0 && !rsp_key_only_line))
      else $error("dropped line carries parse fields");

   a_key_only_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_only_line) |-> (rsp_setting_value == VALUE_KEY_ONLY))
      else $error("key-only line value is not one");

endmodule

// ===== rtl/inikv_ctrl.sv =====
`timescale 1ns / 1ps
module inikv_ctrl import inikv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.finish = (state_ff == ST_FINISH) && !(status.emit && status.out_busy);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.need_finish) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/inikv_dpath.sv =====
`timescale 1ns / 1ps
module inikv_dpath import inikv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [7:0]           req_data_byte,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_write_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [MASK_W-1:0]    rsp_match_mask,
   output logic [VALUE_W-1:0]   rsp_setting_value,
   output logic                 rsp_key_only_line,
   output logic                 rsp_line_too_long,
   output logic                 rsp_end_of_file
);

   // configuration
   logic [KEY_W-1:0]  key_ff [NUM_KEYS];
   logic [KEY_W-1:0]  key_in [NUM_KEYS];
   logic [MASK_W-1:0] kind_ff, kind_in;

   // line state
   mode_type         mode_ff, mode_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;

   // line end snapshot
   logic fin_key_only_ff, fin_key_only_in;
   logic fin_ovf_ff, fin_ovf_in;
   logic fin_parse_ff, fin_parse_in;
   logic fin_eof_ff, fin_eof_in;

   // key tracker
   kphase_type          kphase_ff, kphase_in;
   logic [KLEN_W-1:0]   klen_ff, klen_in;
   logic [NUM_KEYS-1:0] keq_ff, keq_in;

   // value tracker
   vphase_type         vphase_ff, vphase_in;
   logic [VLEN_W-1:0]  vlen_ff, vlen_in;
   logic               vbad_ff, vbad_in;
   logic [VALUE_W-1:0] vnum_ff, vnum_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_key_only_ff, rsp_key_only_in;
   logic               rsp_too_long_ff, rsp_too_long_in;
   logic               rsp_eof_ff, rsp_eof_in;

   // byte classification
   logic is_eol, is_eof, is_semi, is_eq, is_end, is_comment, is_kv, is_content;
   logic fold_now;

   assign is_eol     = (req_data_byte == BYTE_EOL);
   assign is_eof     = (req_data_byte == BYTE_EOF);
   assign is_semi    = (req_data_byte == BYTE_SEMI);
   assign is_eq      = (req_data_byte == BYTE_EQ);
   assign is_end     = is_eol || is_eof;
   assign is_comment = (mode_ff == MODE_COMMENT);
   assign is_kv      = (mode_ff == MODE_KV);
   assign is_content = !is_end && !is_semi;

   assign status.need_finish = is_eof || (!is_comment && (is_semi || is_eol));

   // trailing CR is dropped only at a line or file end
   assign fold_now = cmd.accept && !is_comment && pend_valid_ff &&
                     !(is_end && (pend_ff == BYTE_CR));

   // pending character decode
   logic                 ch_sp, ch_eq, ch_digit;
   logic [3:0]           ch_val;
   logic [7:0]           kbyte [NUM_KEYS];
   logic [VLEN_W-1:0]    run_len;
   logic                 run_bad;
   logic [VALUE_W+3:0]   run_prod;

   assign ch_sp  = (pend_ff == BYTE_SP);
   assign ch_eq  = (pend_ff == BYTE_EQ);
   assign ch_val = pend_ff[3:0];

   always_comb begin
      ch_digit = pend_ff inside {[BYTE_DIGIT_0:BYTE_DIGIT_9]};
   end

   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         kbyte[i] = key_ff[i][{klen_ff[KBYTE_IDX_W-1:0], 3'b000} +: 8];
      end
   end

   assign run_len  = (vlen_ff == VLEN_SAT) ? VLEN_SAT : vlen_ff + VLEN_W'(1);
   assign run_bad  = vbad_ff || (run_len > VLEN_MAX) || !ch_digit ||
                     (vnum_ff > VALUE_CAP_TENTH) ||
                     ((vnum_ff == VALUE_CAP_TENTH) && (ch_val >= VALUE_CAP_DIGIT));
   assign run_prod = ({4'b0000, vnum_ff} << 3) + ({4'b0000, vnum_ff} << 1) +
                     {{VALUE_W{1'b0}}, ch_val};

   // configuration writes
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         key_in[i] = key_ff[i];
         if (csr_write_enable && (csr_index == CSR_IDX_W'(i))) begin
            key_in[i] = csr_write_data;
         end
      end
      kind_in = kind_ff;
      if (csr_write_enable && (csr_index == CSR_KIND_MASK)) begin
         kind_in = csr_write_data[MASK_W-1:0];
      end
   end

   // mode, column, overflow, pending character, line end snapshot
   always_comb begin
      mode_in         = mode_ff;
      col_in          = col_ff;
      ovf_in          = ovf_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      fin_key_only_in = fin_key_only_ff;
      fin_ovf_in      = fin_ovf_ff;
      fin_parse_in    = fin_parse_ff;
      fin_eof_in      = fin_eof_ff;
      if (cmd.accept) begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (is_end) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_KV: begin
               if (is_semi) begin
                  mode_in = MODE_COMMENT;
               end else if (is_end) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               if (is_semi) begin
                  mode_in = MODE_COMMENT;
               end else if (is_end) begin
                  mode_in = MODE_IDLE;
               end else if (is_eq) begin
                  mode_in = MODE_KV;
               end
            end
         endcase

         if (is_end) begin
            col_in = '0;
            ovf_in = 1'b0;
         end else if (is_semi && !is_comment) begin
            ovf_in = 1'b0;
            if (col_ff < COL_LAST) begin
               col_in = col_ff + COL_W'(1);
            end
         end else if (col_ff >= COL_LAST) begin
            if (!is_comment && !is_semi) begin
               ovf_in = 1'b1;
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end

         if (!is_content) begin
            pend_valid_in = 1'b0;
         end else if (!is_comment) begin
            pend_in       = req_data_byte;
            pend_valid_in = 1'b1;
         end

         if (status.need_finish) begin
            fin_key_only_in = !is_kv;
            fin_ovf_in      = ovf_ff;
            fin_parse_in    = !is_comment;
            fin_eof_in      = is_eof;
         end
      end
   end

   // key and value trackers
   always_comb begin
      kphase_in = kphase_ff;
      klen_in   = klen_ff;
      keq_in    = keq_ff;
      vphase_in = vphase_ff;
      vlen_in   = vlen_ff;
      vbad_in   = vbad_ff;
      vnum_in   = vnum_ff;
      if (cmd.finish) begin
         kphase_in = K_LEAD;
         klen_in   = '0;
         keq_in    = '0;
         vphase_in = V_PRE;
         vlen_in   = '0;
         vbad_in   = 1'b0;
         vnum_in   = '0;
      end else if (fold_now) begin
         case (kphase_ff)
            K_LEAD: begin
               if (ch_eq) begin
                  kphase_in = K_DONE;
               end else if (!ch_sp) begin
                  kphase_in = K_RUN;
                  klen_in   = KLEN_W'(1);
                  for (int i = 0; i < NUM_KEYS; i++) begin
                     keq_in[i] = (key_ff[i][7:0] == pend_ff);
                  end
               end
            end
            K_RUN: begin
               if (ch_sp || ch_eq) begin
                  kphase_in = K_DONE;
               end else if (klen_ff < KLEN_MAX) begin
                  klen_in = klen_ff + KLEN_W'(1);
                  for (int i = 0; i < NUM_KEYS; i++) begin
                     keq_in[i] = keq_ff[i] && (kbyte[i] == pend_ff);
                  end
               end else begin
                  klen_in = KLEN_OVER;
               end
            end
            K_DONE: begin
               kphase_in = K_DONE;
            end
            default: begin
               kphase_in = K_DONE;
            end
         endcase

         case (vphase_ff)
            V_PRE: begin
               if (ch_eq) begin
                  vphase_in = V_LEAD;
               end
            end
            V_LEAD, V_RUN: begin
               if (ch_sp) begin
                  if (vphase_ff == V_RUN) begin
                     vphase_in = V_DONE;
                  end
               end else begin
                  vphase_in = V_RUN;
                  vlen_in   = run_len;
                  vbad_in   = run_bad;
                  if (!run_bad) begin
                     vnum_in = run_prod[VALUE_W-1:0];
                  end
               end
            end
            V_DONE: begin
               vphase_in = V_DONE;
            end
            default: begin
               vphase_in = V_DONE;
            end
         endcase
      end
   end

   // line result
   logic               klen_ok, line_hit;
   logic               res_emit;
   logic [MASK_W-1:0]  res_mask;
   logic [VALUE_W-1:0] res_value;

   assign klen_ok  = (klen_ff != '0) && (klen_ff <= KLEN_MAX);
   assign line_hit = fin_parse_ff && !fin_ovf_ff && (klen_ff != '0);
   assign res_emit = fin_eof_ff || (fin_parse_ff && (fin_ovf_ff || (klen_ff != '0)));

   always_comb begin
      res_mask = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         res_mask[i] = line_hit && klen_ok && keq_ff[i] &&
                       ((klen_ff == KLEN_MAX) || (kbyte[i] == 8'h00)) &&
                       (kind_ff[i] == fin_key_only_ff);
      end
      if (!line_hit) begin
         res_value = '0;
      end else if (fin_key_only_ff) begin
         res_value = VALUE_KEY_ONLY;
      end else if (vbad_ff) begin
         res_value = '0;
      end else begin
         res_value = vnum_ff;
      end
   end

   assign status.emit     = res_emit;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_mask_in     = rsp_mask_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_key_only_in = rsp_key_only_ff;
      rsp_too_long_in = rsp_too_long_ff;
      rsp_eof_in      = rsp_eof_ff;
      if (cmd.finish && res_emit) begin
         rsp_valid_in    = 1'b1;
         rsp_mask_in     = res_mask;
         rsp_value_in    = res_value;
         rsp_key_only_in = line_hit && fin_key_only_ff;
         rsp_too_long_in = fin_parse_ff && fin_ovf_ff;
         rsp_eof_in      = fin_eof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_ff[i] <= '0;
         end
         kind_ff       <= '0;
         mode_ff       <= MODE_IDLE;
         col_ff        <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         kphase_ff     <= K_LEAD;
         klen_ff       <= '0;
         keq_ff        <= '0;
         vphase_ff     <= V_PRE;
         vlen_ff       <= '0;
         vbad_ff       <= 1'b0;
         vnum_ff       <= '0;
         fin_key_only_ff <= 1'b0;
         fin_ovf_ff      <= 1'b0;
         fin_parse_ff    <= 1'b0;
         fin_eof_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_ff[i] <= key_in[i];
         end
         kind_ff       <= kind_in;
         mode_ff       <= mode_in;
         col_ff        <= col_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         kphase_ff     <= kphase_in;
         klen_ff       <= klen_in;
         keq_ff        <= keq_in;
         vphase_ff     <= vphase_in;
         vlen_ff       <= vlen_in;
         vbad_ff       <= vbad_in;
         vnum_ff       <= vnum_in;
         fin_key_only_ff <= fin_key_only_in;
         fin_ovf_ff      <= fin_ovf_in;
         fin_parse_ff    <= fin_parse_in;
         fin_eof_ff      <= fin_eof_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff         <= pend_in;
      rsp_mask_ff     <= rsp_mask_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_key_only_ff <= rsp_key_only_in;
      rsp_too_long_ff <= rsp_too_long_in;
      rsp_eof_ff      <= rsp_eof_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_mask    = rsp_mask_ff;
   assign rsp_setting_value = rsp_value_ff;
   assign rsp_key_only_line = rsp_key_only_ff;
   assign rsp_line_too_long = rsp_too_long_ff;
   assign rsp_end_of_file   = rsp_eof_ff;

endmodule
